### src/urbe_pkg.sv
// ----------------------------------------------------------------------------
// urbe_pkg
// Shared types and codes for the uart ring buffer engine: item payloads,
// operation codes and the command/status bundles between control and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package urbe_pkg;

  // operation codes carried in the func field
  localparam logic [1:0] FUNC_EVENT = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // one input item
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] byte_in;
    logic       overrun_flag;
    logic       data_ready;
    logic       tx_empty;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        rbr_taken;
    logic        read_valid;
    logic [7:0]  read_byte;
    logic        write_accepted;
    logic        rx_irq_enable;
    logic        tx_irq_enable;
    logic        rx_wake;
    logic        tx_wake;
    logic [31:0] overrun_total;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the input beat and read both ring memories
    logic commit;   // apply the item and load the result register
  } urbe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free; // result register can take a new beat this cycle
  } urbe_sts_t;

endpackage

`default_nettype wire

### src/uart_ring_buffer_engine.sv
// ----------------------------------------------------------------------------
// uart_ring_buffer_engine
// Receive and transmit byte rings between a 16550-style line and software.
// ----------------------------------------------------------------------------
// Each input beat is a line status event, a software write or a software read
// and yields exactly one result beat. The capture step takes the beat and
// reads both ring memories at their head slots (the memories have a
// registered read port); the commit step then moves the pointers, writes the
// ring and loads the result register. A new beat is taken in the cycle after
// the commit, even while the previous result still waits downstream; the
// commit itself waits only while the result register holds an untaken beat.
// Ring depth is set by RING_DEPTH; ring contents come up undefined after reset
// and need no clearing since a pop only reads slots filled by an earlier push.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_ring_buffer_engine #(
  parameter int RING_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire urbe_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output urbe_pkg::out_item_t     out_data
);
  import urbe_pkg::*;

  urbe_cmd_t cmd;
  urbe_sts_t sts;

  // sequencer
  urbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // rings and result register
  urbe_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### src/urbe_ctrl.sv
// ----------------------------------------------------------------------------
// urbe_ctrl
// Item sequencer: takes one input beat, then waits for the result register
// to be free and commits the item.
// ----------------------------------------------------------------------------
`default_nettype none

module urbe_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire urbe_pkg::urbe_sts_t sts,
  output urbe_pkg::urbe_cmd_t     cmd
);
  import urbe_pkg::*;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  // command decode
  always_comb begin
    cmd.capture = (state == ST_IDLE) && in_valid;
    cmd.commit  = (state == ST_EXEC) && sts.out_free;
  end

  // state and stall register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_stall <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state    <= ST_EXEC;
            in_stall <= 1'b1;
          end
        end
        ST_EXEC: begin
          if (sts.out_free) begin
            state    <= ST_IDLE;
            in_stall <= 1'b0;
          end
        end
        default: begin
          state    <= ST_IDLE;
          in_stall <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### src/urbe_datapath.sv
// ----------------------------------------------------------------------------
// urbe_datapath
// Receive and transmit rings with their pointers, interrupt enables,
// overrun counter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module urbe_datapath #(
  parameter int RING_DEPTH = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire urbe_pkg::in_item_t  in_data,
  input  wire urbe_pkg::urbe_cmd_t cmd,
  output urbe_pkg::urbe_sts_t      sts,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output urbe_pkg::out_item_t      out_data
);
  import urbe_pkg::*;

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int PW = AW + 1;
  localparam logic [PW:0]   SPAN  = (PW + 1)'(2 * RING_DEPTH);
  localparam logic [PW:0]   DEPTH = (PW + 1)'(RING_DEPTH);
  localparam logic [PW-1:0] LAST  = PW'(2 * RING_DEPTH - 1);
  localparam logic [PW-1:0] DEPTH_P = PW'(RING_DEPTH);

  // pointer helpers: pointers run modulo twice the depth
  function automatic logic [PW-1:0] advance(input logic [PW-1:0] ptr);
    advance = (ptr == LAST) ? '0 : ptr + PW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_of(input logic [PW-1:0] ptr);
    logic [PW-1:0] s;
    s = (ptr >= DEPTH_P) ? ptr - DEPTH_P : ptr;
    slot_of = s[AW-1:0];
  endfunction

  function automatic logic [PW:0] occupancy(input logic [PW-1:0] head,
                                            input logic [PW-1:0] tail);
    logic [PW:0] wrap;
    wrap = (tail < head) ? SPAN : '0;
    occupancy = {1'b0, tail} + wrap - {1'b0, head};
  endfunction

  logic [7:0] rx_mem [RING_DEPTH];
  logic [7:0] tx_mem [RING_DEPTH];
  logic [7:0] rx_rd_data;
  logic [7:0] tx_rd_data;

  in_item_t    item;
  logic [PW-1:0] rx_head, rx_tail, tx_head, tx_tail;
  logic [PW-1:0] rx_head_next, rx_tail_next, tx_head_next, tx_tail_next;
  logic          rx_ie, tx_ie, rx_ie_next, tx_ie_next;
  logic [31:0]   overrun_count, overrun_count_next;
  logic          rx_we, tx_we;
  logic          rx_full, rx_ring_empty, tx_full, tx_ring_empty;
  out_item_t     res;

  // ring status
  always_comb begin
    rx_full       = occupancy(rx_head, rx_tail) >= DEPTH;
    tx_full       = occupancy(tx_head, tx_tail) >= DEPTH;
    rx_ring_empty = (rx_head == rx_tail);
    tx_ring_empty = (tx_head == tx_tail);
  end

  // item execution
  always_comb begin
    rx_head_next       = rx_head;
    rx_tail_next       = rx_tail;
    tx_head_next       = tx_head;
    tx_tail_next       = tx_tail;
    rx_ie_next         = rx_ie;
    tx_ie_next         = tx_ie;
    overrun_count_next = overrun_count;
    rx_we              = 1'b0;
    tx_we              = 1'b0;
    res                = '0;
    case (item.func)
      FUNC_EVENT: begin
        if (item.overrun_flag) begin
          overrun_count_next = overrun_count + 32'd1;
        end
        if (item.data_ready) begin
          if (!rx_full) begin
            rx_we         = 1'b1;
            rx_tail_next  = advance(rx_tail);
            res.rbr_taken = 1'b1;
            res.rx_wake   = rx_ring_empty;
          end else begin
            rx_ie_next = 1'b0;
          end
        end
        if (item.tx_empty) begin
          if (!tx_ring_empty) begin
            tx_head_next = advance(tx_head);
            res.tx_valid = 1'b1;
            res.tx_byte  = tx_rd_data;
            res.tx_wake  = tx_full;
          end else begin
            tx_ie_next = 1'b0;
          end
        end
      end
      FUNC_WRITE: begin
        if (!tx_full) begin
          tx_we              = 1'b1;
          tx_tail_next       = advance(tx_tail);
          res.write_accepted = 1'b1;
          tx_ie_next         = 1'b1;
        end
      end
      FUNC_READ: begin
        if (!rx_ring_empty) begin
          rx_head_next   = advance(rx_head);
          res.read_valid = 1'b1;
          res.read_byte  = rx_rd_data;
          rx_ie_next     = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.rx_irq_enable = rx_ie_next;
    res.tx_irq_enable = tx_ie_next;
    res.overrun_total = overrun_count_next;
  end

  // ring memories, read at the heads when a beat is taken
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rx_rd_data <= rx_mem[slot_of(rx_head)];
      tx_rd_data <= tx_mem[slot_of(tx_head)];
    end
    if (cmd.commit && rx_we) begin
      rx_mem[slot_of(rx_tail)] <= item.byte_in;
    end
    if (cmd.commit && tx_we) begin
      tx_mem[slot_of(tx_tail)] <= item.byte_in;
    end
  end

  // input and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
    end
    if (cmd.commit) begin
      out_data <= res;
    end
  end

  // pointers, enables, counter, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head       <= '0;
      rx_tail       <= '0;
      tx_head       <= '0;
      tx_tail       <= '0;
      rx_ie         <= 1'b1;
      tx_ie         <= 1'b0;
      overrun_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.commit) begin
        rx_head       <= rx_head_next;
        rx_tail       <= rx_tail_next;
        tx_head       <= tx_head_next;
        tx_tail       <= tx_tail_next;
        rx_ie         <= rx_ie_next;
        tx_ie         <= tx_ie_next;
        overrun_count <= overrun_count_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.out_free = !out_valid || !out_stall;

endmodule

`default_nettype wire

### tb/sv/tb_uart_ring_buffer_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_ring_buffer_engine
// Self-checking bench for the uart ring buffer engine. A short table of line
// events, software writes and reads (some with hand-typed results) is
// followed by random bursts that fill and drain both rings past full and
// empty. Every result beat is compared field by field with its hand-typed
// result or a ring-level prediction kept in the bench. Both handshake sides
// idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------

module tb_uart_ring_buffer_engine;

  import urbe_pkg::*;

  localparam int         RING_SLOTS   = 64;
  localparam int         RANDOM_ITEMS = 1500;
  localparam int         HOLD_AT      = 300;
  localparam int         HOLD_CYCLES  = 300;
  localparam logic [1:0] FUNC_UNUSED  = 2'd3;

  typedef struct {
    in_item_t  item;
    bit        known;
    out_item_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // ring-level copy of the block state
  bit [7:0]    rx_ring [RING_SLOTS];
  bit [7:0]    tx_ring [RING_SLOTS];
  logic [6:0]  rx_rd = '0, rx_wr = '0, tx_rd = '0, tx_wr = '0;
  logic        rx_en = 1'b1, tx_en = 1'b0;
  logic [31:0] ovr_cnt = '0;

  out_item_t   pending_results [$];
  stim_row_t   directed_rows [$];
  int          n_accepted = 0;
  int          n_results  = 0;
  int          n_errors   = 0;

  uart_ring_buffer_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #(64'd20_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic in_item_t mk_item(logic [1:0] f, logic [7:0] b, logic ovr, logic dr,
                                       logic te);
    in_item_t it;
    it.func         = f;
    it.byte_in      = b;
    it.overrun_flag = ovr;
    it.data_ready   = dr;
    it.tx_empty     = te;
    return it;
  endfunction

  function automatic out_item_t mk_result(logic txv, logic [7:0] txb, logic taken, logic rdv,
                                          logic [7:0] rdb, logic wacc, logic rxie, logic txie,
                                          logic rxw, logic txw, logic [31:0] ovr);
    out_item_t r;
    r.tx_valid       = txv;
    r.tx_byte        = txb;
    r.rbr_taken      = taken;
    r.read_valid     = rdv;
    r.read_byte      = rdb;
    r.write_accepted = wacc;
    r.rx_irq_enable  = rxie;
    r.tx_irq_enable  = txie;
    r.rx_wake        = rxw;
    r.tx_wake        = txw;
    r.overrun_total  = ovr;
    return r;
  endfunction

  // apply one item to the ring copy and return the result it yields
  function automatic out_item_t ring_step(in_item_t it);
    out_item_t  r;
    logic [6:0] fill;
    r = '0;
    case (it.func)
      FUNC_EVENT: begin
        if (it.overrun_flag) ovr_cnt = ovr_cnt + 32'd1;
        if (it.data_ready) begin
          fill = rx_wr - rx_rd;
          if (fill < 7'(RING_SLOTS)) begin
            r.rx_wake = (fill == 7'd0);
            rx_ring[rx_wr[5:0]] = it.byte_in;
            rx_wr = rx_wr + 7'd1;
            r.rbr_taken = 1'b1;
          end else begin
            rx_en = 1'b0;
          end
        end
        if (it.tx_empty) begin
          fill = tx_wr - tx_rd;
          if (fill != 7'd0) begin
            r.tx_wake = (fill >= 7'(RING_SLOTS));
            r.tx_byte = tx_ring[tx_rd[5:0]];
            tx_rd = tx_rd + 7'd1;
            r.tx_valid = 1'b1;
          end else begin
            tx_en = 1'b0;
          end
        end
      end
      FUNC_WRITE: begin
        fill = tx_wr - tx_rd;
        if (fill < 7'(RING_SLOTS)) begin
          tx_ring[tx_wr[5:0]] = it.byte_in;
          tx_wr = tx_wr + 7'd1;
          r.write_accepted = 1'b1;
          tx_en = 1'b1;
        end
      end
      FUNC_READ: begin
        fill = rx_wr - rx_rd;
        if (fill != 7'd0) begin
          r.read_byte = rx_ring[rx_rd[5:0]];
          rx_rd = rx_rd + 7'd1;
          r.read_valid = 1'b1;
          rx_en = 1'b1;
        end
      end
      default: ;
    endcase
    r.rx_irq_enable = rx_en;
    r.tx_irq_enable = tx_en;
    r.overrun_total = ovr_cnt;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR result %0d: %s", n_results, msg);
    n_errors++;
  endtask

  task automatic add_row(input in_item_t it, input bit known, input out_item_t want);
    stim_row_t row;
    row.item  = it;
    row.known = known;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // sender gap: mostly none, some short, a few long
  function automatic int sender_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // offer one beat, wait for it to be taken, then log its expected result
  task automatic offer_beat(input in_item_t it, input bit quiet, input bit known,
                            input out_item_t want);
    int        gap;
    out_item_t pred;
    gap = quiet ? 0 : sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    pred = ring_step(it);
    pending_results.push_back(known ? want : pred);
    n_accepted++;
  endtask

  // result side stall pattern, with one long hold-off once traffic is flowing
  initial begin : stall_gen
    int run;
    int p;
    bit held;
    held = 1'b0;
    forever begin
      if (!held && n_accepted >= HOLD_AT) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        run = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6);
        repeat (run) @(posedge clk);
        out_stall <= 1'b1;
        p = $urandom_range(0, 99);
        if (p < 75) run = $urandom_range(1, 3);
        else if (p < 95) run = $urandom_range(4, 10);
        else run = $urandom_range(20, 40);
        repeat (run) @(posedge clk);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_mon
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (out_data.tx_valid !== want.tx_valid)
          report_mismatch($sformatf("tx_valid got %0d want %0d",
                                    out_data.tx_valid, want.tx_valid));
        if (out_data.tx_byte !== want.tx_byte)
          report_mismatch($sformatf("tx_byte got %h want %h",
                                    out_data.tx_byte, want.tx_byte));
        if (out_data.rbr_taken !== want.rbr_taken)
          report_mismatch($sformatf("rbr_taken got %0d want %0d",
                                    out_data.rbr_taken, want.rbr_taken));
        if (out_data.read_valid !== want.read_valid)
          report_mismatch($sformatf("read_valid got %0d want %0d",
                                    out_data.read_valid, want.read_valid));
        if (out_data.read_byte !== want.read_byte)
          report_mismatch($sformatf("read_byte got %h want %h",
                                    out_data.read_byte, want.read_byte));
        if (out_data.write_accepted !== want.write_accepted)
          report_mismatch($sformatf("write_accepted got %0d want %0d",
                                    out_data.write_accepted, want.write_accepted));
        if (out_data.rx_irq_enable !== want.rx_irq_enable)
          report_mismatch($sformatf("rx_irq_enable got %0d want %0d",
                                    out_data.rx_irq_enable, want.rx_irq_enable));
        if (out_data.tx_irq_enable !== want.tx_irq_enable)
          report_mismatch($sformatf("tx_irq_enable got %0d want %0d",
                                    out_data.tx_irq_enable, want.tx_irq_enable));
        if (out_data.rx_wake !== want.rx_wake)
          report_mismatch($sformatf("rx_wake got %0d want %0d",
                                    out_data.rx_wake, want.rx_wake));
        if (out_data.tx_wake !== want.tx_wake)
          report_mismatch($sformatf("tx_wake got %0d want %0d",
                                    out_data.tx_wake, want.tx_wake));
        if (out_data.overrun_total !== want.overrun_total)
          report_mismatch($sformatf("overrun_total got %0d want %0d",
                                    out_data.overrun_total, want.overrun_total));
      end
      n_results++;
    end
  end

  // stimulus
  initial begin : stim
    in_item_t  it;
    out_item_t idle_r;
    int        kind;
    int        len;
    int        n_counted;
    bit        quiet;

    idle_r = mk_result(0, 8'h00, 0, 0, 8'h00, 0, 1, 0, 0, 0, 32'd0);

    // directed table: reset state, extremes, empty/unused cases, then a short exchange
    add_row(mk_item(FUNC_READ,   8'hFF, 1, 1, 1), 1, idle_r);
    add_row(mk_item(FUNC_EVENT,  8'h00, 0, 0, 1), 1, idle_r);
    add_row(mk_item(FUNC_UNUSED, 8'hFF, 1, 1, 1), 1, idle_r);
    add_row(mk_item(FUNC_EVENT,  8'h00, 1, 1, 0), 1,
            mk_result(0, 8'h00, 1, 0, 8'h00, 0, 1, 0, 1, 0, 32'd1));
    add_row(mk_item(FUNC_EVENT,  8'hFF, 1, 1, 0), 1,
            mk_result(0, 8'h00, 1, 0, 8'h00, 0, 1, 0, 0, 0, 32'd2));
    add_row(mk_item(FUNC_READ,   8'h00, 0, 0, 0), 1,
            mk_result(0, 8'h00, 0, 1, 8'h00, 0, 1, 0, 0, 0, 32'd2));
    add_row(mk_item(FUNC_READ,   8'h00, 0, 0, 0), 1,
            mk_result(0, 8'h00, 0, 1, 8'hFF, 0, 1, 0, 0, 0, 32'd2));
    add_row(mk_item(FUNC_READ,   8'h00, 0, 0, 0), 1,
            mk_result(0, 8'h00, 0, 0, 8'h00, 0, 1, 0, 0, 0, 32'd2));
    add_row(mk_item(FUNC_WRITE,  8'h00, 1, 1, 1), 1,
            mk_result(0, 8'h00, 0, 0, 8'h00, 1, 1, 1, 0, 0, 32'd2));
    add_row(mk_item(FUNC_WRITE,  8'hFF, 0, 0, 0), 1,
            mk_result(0, 8'h00, 0, 0, 8'h00, 1, 1, 1, 0, 0, 32'd2));
    add_row(mk_item(FUNC_WRITE,  8'hA5, 1, 0, 1), 1,
            mk_result(0, 8'h00, 0, 0, 8'h00, 1, 1, 1, 0, 0, 32'd2));
    add_row(mk_item(FUNC_EVENT,  8'h5A, 0, 1, 1), 1,
            mk_result(1, 8'h00, 1, 0, 8'h00, 0, 1, 1, 1, 0, 32'd2));
    add_row(mk_item(FUNC_EVENT,  8'h00, 1, 0, 1), 0, '0);
    add_row(mk_item(FUNC_EVENT,  8'hC3, 0, 0, 1), 0, '0);
    add_row(mk_item(FUNC_EVENT,  8'h00, 0, 0, 1), 0, '0);
    add_row(mk_item(FUNC_READ,   8'hFF, 1, 1, 1), 0, '0);
    add_row(mk_item(FUNC_EVENT,  8'h77, 0, 0, 0), 0, '0);
    add_row(mk_item(FUNC_WRITE,  8'h3C, 0, 0, 0), 0, '0);
    add_row(mk_item(FUNC_READ,   8'h00, 0, 0, 0), 0, '0);
    add_row(mk_item(FUNC_UNUSED, 8'h00, 0, 0, 0), 0, '0);
    add_row(mk_item(FUNC_EVENT,  8'h80, 1, 0, 1), 0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      offer_beat(directed_rows[i].item, 1'b0, directed_rows[i].known, directed_rows[i].want);

    // random bursts: fill and drain both rings past their limits, plus noise
    n_counted = 0;
    while (n_counted < RANDOM_ITEMS) begin
      kind  = $urandom_range(0, 9);
      len   = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      quiet = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < len; k++) begin
        case (kind)
          0, 1: it = mk_item(FUNC_WRITE, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
          2, 3: it = mk_item(FUNC_EVENT, 8'($urandom_range(0, 255)),
                             $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0, 1'b1);
          4, 5: it = mk_item(FUNC_EVENT, 8'($urandom_range(0, 255)),
                             $urandom_range(0, 7) == 0, 1'b1, $urandom_range(0, 3) == 0);
          6, 7: it = mk_item(FUNC_READ, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
          8:    it = mk_item(FUNC_EVENT, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
          default: it = mk_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)));
        endcase
        offer_beat(it, quiet, 1'b0, '0);
        if (it.func != FUNC_UNUSED) n_counted++;
      end
    end
    in_valid <= 1'b0;

    // drain, then keep watching the result side to catch stray beats
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (n_errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
